[design/imhe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhe_pkg
// Shared constants and operation codes for the indexed min-heap engine.
// ----------------------------------------------------------------------------
package imhe_pkg;

    localparam int HEAP_DEPTH_DEF   = 1024;
    localparam int HANDLE_SPACE_DEF = 4096;
    localparam int VALUE_WIDTH_DEF  = 32;

    localparam int OP_W      = 3;
    localparam int VALUE_W   = 32;
    localparam int HANDLE_W  = 12;
    localparam int COUNT_W   = 11;

    localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [OP_W-1:0] OP_EXTRACT = 3'd1;
    localparam logic [OP_W-1:0] OP_GET     = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd3;
    localparam logic [OP_W-1:0] OP_CHANGE  = 3'd4;
    localparam logic [OP_W-1:0] OP_SIZE    = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd6;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

endpackage

[design/imhe_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhe_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module imhe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/indexed_min_heap_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_engine
// Binary min-heap priority queue with handles, one result per request.
// ----------------------------------------------------------------------------
// A request transfers when start is high and busy is low; its single result
// appears for exactly one cycle with done high and cannot be held off, so
// take it in the cycle it is shown. Size, clear and a rejected insert,
// extract-min, get-min or unknown op complete in the cycle after the
// transfer. Get-min completes once the root is read; a rejected delete or
// change completes at the handle lookup or at the slot check. Insert,
// extract-min, delete and change re-sift one entry through the slot memory
// unless the entry removed was the last one: each level going up reads the
// parent, then compares and moves; each level going down reads the left
// child, reads the right child, then compares and moves (comparing after
// the left read where only a left child exists). Further steps look up the
// handle or fetch the last entry, and a closing step drops the held entry
// into its final slot. The single read port of the slot memory is why the
// two children are read one after the other.
// A handle is checked by looking up its slot and confirming the slot holds
// that same handle, so clear needs no sweep and the position memory needs
// no initialization after reset.
// ----------------------------------------------------------------------------
module indexed_min_heap_engine #(
    parameter int HEAP_DEPTH   = imhe_pkg::HEAP_DEPTH_DEF,
    parameter int HANDLE_SPACE = imhe_pkg::HANDLE_SPACE_DEF,
    parameter int VALUE_WIDTH  = imhe_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [imhe_pkg::OP_W-1:0]           op,
    input  logic signed [imhe_pkg::VALUE_W-1:0] item_value,
    input  logic [imhe_pkg::HANDLE_W-1:0]       handle,
    output logic                                done,
    output logic                                status,
    output logic signed [imhe_pkg::VALUE_W-1:0] result_value,
    output logic [imhe_pkg::COUNT_W-1:0]        count
);

    import imhe_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int HW = $clog2(HANDLE_SPACE);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int SW = VW + HW;
    localparam int XW = HW + HANDLE_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TOP  = 4'd1;
    localparam logic [3:0] S_LAST = 4'd2;
    localparam logic [3:0] S_POS  = 4'd3;
    localparam logic [3:0] S_HCHK = 4'd4;
    localparam logic [3:0] S_DRD  = 4'd5;
    localparam logic [3:0] S_DL   = 4'd6;
    localparam logic [3:0] S_DR   = 4'd7;
    localparam logic [3:0] S_URD  = 4'd8;
    localparam logic [3:0] S_UW   = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    logic [3:0]          state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [HANDLE_W-1:0] hdl_reg, hdl_next;
    logic [VW-1:0]       cur_val_reg, cur_val_next;
    logic [HW-1:0]       cur_hdl_reg, cur_hdl_next;
    logic [VW-1:0]       lval_reg, lval_next;
    logic [HW-1:0]       lhdl_reg, lhdl_next;
    logic [CW-1:0]       p_reg, p_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [HW-1:0]       issued_reg, issued_next;
    logic                done_reg, done_next;
    logic                status_reg, status_next;
    logic [VW-1:0]       res_reg, res_next;

    // memory ports
    logic          slot_we;
    logic [AW-1:0] slot_waddr, slot_raddr;
    logic [SW-1:0] slot_wdata, slot_rdata;
    logic          pos_we;
    logic [HW-1:0] pos_waddr, pos_raddr;
    logic [CW-1:0] pos_wdata, pos_rdata;

    logic [VW-1:0] rd_val;
    logic [HW-1:0] rd_hdl;
    logic [CW:0]   lidx, ridx, count_x;
    logic          accept;
    logic          bad_handle;
    logic          rd_lt_cur, rd_lt_left, left_lt_cur;

    // heap slots, 1-based slot p lives at address p-1: {handle, value}
    imhe_ram #(.WIDTH(SW), .DEPTH(HEAP_DEPTH)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // slot position of each handle
    imhe_ram #(.WIDTH(CW), .DEPTH(HANDLE_SPACE)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    assign rd_val  = slot_rdata[VW-1:0];
    assign rd_hdl  = slot_rdata[SW-1:VW];
    assign lidx    = {p_reg, 1'b0};
    assign ridx    = lidx + (CW+1)'(1);
    assign count_x = (CW+1)'(count_reg);
    assign accept  = start && (state_reg == S_IDLE);

    assign rd_lt_cur   = $signed(rd_val) < $signed(cur_val_reg);
    assign rd_lt_left  = $signed(rd_val) < $signed(lval_reg);
    assign left_lt_cur = $signed(lval_reg) < $signed(cur_val_reg);

    // reject handle zero, handles not yet issued or out of range, and stale slots
    assign bad_handle = (hdl_reg == '0)
                     || (XW'(hdl_reg) > XW'(issued_reg))
                     || (XW'(hdl_reg) >= XW'(HANDLE_SPACE))
                     || (pos_rdata == '0)
                     || (pos_rdata > count_reg);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        hdl_next     = hdl_reg;
        cur_val_next = cur_val_reg;
        cur_hdl_next = cur_hdl_reg;
        lval_next    = lval_reg;
        lhdl_next    = lhdl_reg;
        p_next       = p_reg;
        count_next   = count_reg;
        issued_next  = issued_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        res_next     = res_reg;
        slot_we      = 1'b0;
        slot_waddr   = AW'(p_reg - CW'(1));
        slot_wdata   = {cur_hdl_reg, cur_val_reg};
        slot_raddr   = '0;
        pos_we       = 1'b0;
        pos_waddr    = cur_hdl_reg;
        pos_wdata    = p_reg;
        pos_raddr    = HW'(handle);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = op;
                    hdl_next     = handle;
                    cur_val_next = VW'($unsigned(item_value));
                    res_next     = '0;
                    case (op)
                        OP_INSERT:
                        begin
                            if ((count_reg == CW'(HEAP_DEPTH))
                                || (issued_reg == HW'(HANDLE_SPACE - 1)))
                            begin
                                done_next   = 1'b1;
                                status_next = STATUS_ERR;
                            end
                            else
                            begin
                                issued_next  = issued_reg + HW'(1);
                                cur_hdl_next = issued_reg + HW'(1);
                                count_next   = count_reg + CW'(1);
                                p_next       = count_reg + CW'(1);
                                state_next   = S_DRD;
                            end
                        end
                        OP_EXTRACT, OP_GET:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = STATUS_ERR;
                            end
                            else
                            begin
                                state_next = S_TOP;
                            end
                        end
                        OP_DELETE, OP_CHANGE:
                        begin
                            state_next = S_POS;
                        end
                        OP_SIZE:
                        begin
                            done_next   = 1'b1;
                            status_next = STATUS_OK;
                        end
                        OP_CLEAR:
                        begin
                            count_next  = '0;
                            done_next   = 1'b1;
                            status_next = STATUS_OK;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = STATUS_ERR;
                        end
                    endcase
                end
            end
            S_TOP:
            begin
                res_next = rd_val;
                if (op_reg == OP_GET)
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_OK;
                    state_next  = S_IDLE;
                end
                else if (count_reg == CW'(1))
                begin
                    count_next  = '0;
                    done_next   = 1'b1;
                    status_next = STATUS_OK;
                    state_next  = S_IDLE;
                end
                else
                begin
                    // move the last entry to the root and sift it down
                    count_next = count_reg - CW'(1);
                    slot_raddr = AW'(count_reg - CW'(1));
                    p_next     = CW'(1);
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                cur_val_next = rd_val;
                cur_hdl_next = rd_hdl;
                state_next   = S_DRD;
            end
            S_POS:
            begin
                if (bad_handle)
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_ERR;
                    state_next  = S_IDLE;
                end
                else
                begin
                    p_next     = pos_rdata;
                    slot_raddr = AW'(pos_rdata - CW'(1));
                    state_next = S_HCHK;
                end
            end
            S_HCHK:
            begin
                if (rd_hdl != HW'(hdl_reg))
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_ERR;
                    state_next  = S_IDLE;
                end
                else if (op_reg == OP_CHANGE)
                begin
                    cur_hdl_next = HW'(hdl_reg);
                    state_next   = S_DRD;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    if (p_reg == count_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_OK;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        slot_raddr = AW'(count_reg - CW'(1));
                        state_next = S_LAST;
                    end
                end
            end
            S_DRD:
            begin
                if (lidx > count_x)
                begin
                    state_next = S_URD;
                end
                else
                begin
                    slot_raddr = AW'(lidx - (CW+1)'(1));
                    state_next = S_DL;
                end
            end
            S_DL:
            begin
                lval_next = rd_val;
                lhdl_next = rd_hdl;
                if (ridx <= count_x)
                begin
                    slot_raddr = AW'(ridx - (CW+1)'(1));
                    state_next = S_DR;
                end
                else if (rd_lt_cur)
                begin
                    // pull left child up into the hole
                    slot_we    = 1'b1;
                    slot_wdata = slot_rdata;
                    pos_we     = 1'b1;
                    pos_waddr  = rd_hdl;
                    p_next     = CW'(lidx);
                    state_next = S_DRD;
                end
                else
                begin
                    state_next = S_URD;
                end
            end
            S_DR:
            begin
                if (rd_lt_cur && rd_lt_left)
                begin
                    slot_we    = 1'b1;
                    slot_wdata = slot_rdata;
                    pos_we     = 1'b1;
                    pos_waddr  = rd_hdl;
                    p_next     = CW'(ridx);
                    state_next = S_DRD;
                end
                else if (left_lt_cur)
                begin
                    slot_we    = 1'b1;
                    slot_wdata = {lhdl_reg, lval_reg};
                    pos_we     = 1'b1;
                    pos_waddr  = lhdl_reg;
                    p_next     = CW'(lidx);
                    state_next = S_DRD;
                end
                else
                begin
                    state_next = S_URD;
                end
            end
            S_URD:
            begin
                if (p_reg == CW'(1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    slot_raddr = AW'((p_reg >> 1) - CW'(1));
                    state_next = S_UW;
                end
            end
            S_UW:
            begin
                if (rd_lt_cur == 1'b0 && ($signed(cur_val_reg) < $signed(rd_val)))
                begin
                    // push parent down into the hole
                    slot_we    = 1'b1;
                    slot_wdata = slot_rdata;
                    pos_we     = 1'b1;
                    pos_waddr  = rd_hdl;
                    p_next     = p_reg >> 1;
                    state_next = S_URD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // drop the held entry into its final slot
                slot_we     = 1'b1;
                pos_we      = 1'b1;
                done_next   = 1'b1;
                status_next = STATUS_OK;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            issued_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            issued_reg <= issued_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        hdl_reg     <= hdl_next;
        cur_val_reg <= cur_val_next;
        cur_hdl_reg <= cur_hdl_next;
        lval_reg    <= lval_next;
        lhdl_reg    <= lhdl_next;
        p_reg       <= p_next;
        status_reg  <= status_next;
        res_reg     <= res_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign result_value = VALUE_W'(res_reg);
    assign count        = COUNT_W'(count_reg);

endmodule
